[rtl/multi_channel_soft_timer_bank_core_assert.svh]
// Assertion macros shared by the timer bank modules.
// Each macro expects clk and rst_n in scope.
`ifndef MULTI_CHANNEL_SOFT_TIMER_BANK_CORE_ASSERT_SVH
`define MULTI_CHANNEL_SOFT_TIMER_BANK_CORE_ASSERT_SVH

// Same-cycle implication.
`define MCSTB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MCSTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mcstb_pkg.sv]
package mcstb_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int COUNT_BITS_DEF   = 32;

  localparam int REQ_W    = 3;
  localparam int CH_W     = 4;
  localparam int RELOAD_W = 32;
  localparam int GRANT_W  = 3;
  localparam int MASK_W   = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 3'd0,
    REQ_ALLOC  = 3'd1,
    REQ_CONFIG = 3'd2,
    REQ_START  = 3'd3,
    REQ_STOP   = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic sweep_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic req_tick;
    logic sweep_last;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/mcstb_req_if.sv]
interface mcstb_req_if;
  import mcstb_pkg::*;

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [CH_W-1:0]     channel;
  logic                periodic;
  logic [RELOAD_W-1:0] reload_value;

  modport source (output valid, output req_type, output channel, output periodic,
                  output reload_value, input ready);
  modport sink (input valid, input req_type, input channel, input periodic,
                input reload_value, output ready);
endinterface

[rtl/mcstb_rsp_if.sv]
interface mcstb_rsp_if;
  import mcstb_pkg::*;

  logic               valid;
  logic               ready;
  logic               ok;
  logic [GRANT_W-1:0] granted_channel;
  logic [MASK_W-1:0]  expired_mask;

  modport source (output valid, output ok, output granted_channel, output expired_mask,
                  input ready);
  modport sink (input valid, input ok, input granted_channel, input expired_mask,
                output ready);
endinterface

[rtl/mcstb_ctrl.sv]
`include "multi_channel_soft_timer_bank_core_assert.svh"

module mcstb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mcstb_pkg::dp_status_t sts,
  output mcstb_pkg::ctrl_cmd_t  cmd
);
  import mcstb_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (!sts.req_tick || sts.sweep_last) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.capture    = 1'b0;
    cmd.sweep_step = 1'b0;
    cmd.finish     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_SWEEP:  cmd.sweep_step = sts.req_tick;
      ST_FINISH: cmd.finish     = sts.out_free;
      default: ;
    endcase
  end

  `MCSTB_ASSERT_NEXT(a_capture_to_sweep, cmd.capture, state_r == ST_SWEEP,
                     "capture did not enter sweep")
  `MCSTB_ASSERT_NEXT(a_nontick_skips, (state_r == ST_SWEEP) && !sts.req_tick,
                     state_r == ST_FINISH, "non-tick request lingered in sweep")
  `MCSTB_ASSERT_NEXT(a_finish_holds, (state_r == ST_FINISH) && !sts.out_free,
                     state_r == ST_FINISH, "finish left while output slot busy")

endmodule

[rtl/mcstb_dp.sv]
`include "multi_channel_soft_timer_bank_core_assert.svh"

module mcstb_dp #(
  parameter int NUM_CHANNELS = mcstb_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_BITS   = mcstb_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mcstb_pkg::ctrl_cmd_t            cmd,
  output mcstb_pkg::dp_status_t           sts,
  input  logic [mcstb_pkg::REQ_W-1:0]     in_req_type,
  input  logic [mcstb_pkg::CH_W-1:0]      in_channel,
  input  logic                            in_periodic,
  input  logic [mcstb_pkg::RELOAD_W-1:0]  in_reload_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_ok,
  output logic [mcstb_pkg::GRANT_W-1:0]   out_granted_channel,
  output logic [mcstb_pkg::MASK_W-1:0]    out_expired_mask
);
  import mcstb_pkg::*;

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int USE_W    = $clog2(NUM_CHANNELS + 1);

  // channel state
  logic                  en_r   [NUM_CHANNELS];
  logic                  rep_r  [NUM_CHANNELS];
  logic [COUNT_BITS-1:0] cnt_r  [NUM_CHANNELS];
  logic [COUNT_BITS-1:0] per_r  [NUM_CHANNELS];
  logic [USE_W-1:0]      in_use_r;

  // captured request
  req_t                  req_r;
  logic [CH_W-1:0]       ch_r;
  logic                  rep_req_r;
  logic [COUNT_BITS-1:0] reload_r;

  logic [CH_IDX_W-1:0]     sweep_r;
  logic [NUM_CHANNELS-1:0] mask_r;

  logic               out_valid_r;
  logic               out_ok_r;
  logic [GRANT_W-1:0] out_grant_r;
  logic [MASK_W-1:0]  out_mask_r;

  logic                  sweep_act;
  logic [COUNT_BITS-1:0] cnt_nxt;
  logic                  expire;
  logic                  ch_ok;
  logic [CH_IDX_W-1:0]   ch_idx;
  logic                  alloc_ok;
  logic                  ok_nxt;
  logic [GRANT_W-1:0]    grant_nxt;

  assign sts.req_tick   = (req_r == REQ_TICK);
  assign sts.sweep_last = (sweep_r == CH_IDX_W'(NUM_CHANNELS - 1));
  assign sts.out_free   = !out_valid_r || out_ready;

  // sweep datapath: one increment and compare per cycle
  assign sweep_act = (USE_W'(sweep_r) < in_use_r) && en_r[sweep_r];
  assign cnt_nxt   = cnt_r[sweep_r] + COUNT_BITS'(1);
  assign expire    = (cnt_nxt >= per_r[sweep_r]);

  assign ch_ok    = (ch_r < CH_W'(NUM_CHANNELS));
  assign ch_idx   = ch_r[CH_IDX_W-1:0];
  assign alloc_ok = (in_use_r < USE_W'(NUM_CHANNELS));

  always_comb begin
    ok_nxt    = 1'b0;
    grant_nxt = '0;
    unique case (req_r)
      REQ_TICK:  ok_nxt = 1'b1;
      REQ_ALLOC: begin
        ok_nxt = alloc_ok;
        if (alloc_ok) grant_nxt = GRANT_W'(in_use_r);
      end
      REQ_CONFIG, REQ_START, REQ_STOP: ok_nxt = ch_ok;
      default: ok_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r     <= req_t'(in_req_type);
      ch_r      <= in_channel;
      rep_req_r <= in_periodic;
      reload_r  <= in_reload_value[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        en_r[i]  <= 1'b0;
        rep_r[i] <= 1'b0;
        cnt_r[i] <= '0;
        per_r[i] <= '0;
      end
      in_use_r <= '0;
      sweep_r  <= '0;
      mask_r   <= '0;
    end else if (cmd.capture) begin
      sweep_r <= '0;
      mask_r  <= '0;
    end else if (cmd.sweep_step) begin
      if (sweep_act) begin
        if (expire) begin
          mask_r[sweep_r] <= 1'b1;
          cnt_r[sweep_r]  <= '0;
          if (!rep_r[sweep_r]) en_r[sweep_r] <= 1'b0;
        end else begin
          cnt_r[sweep_r] <= cnt_nxt;
        end
      end
      if (!sts.sweep_last) sweep_r <= sweep_r + CH_IDX_W'(1);
    end else if (cmd.finish) begin
      unique case (req_r)
        REQ_ALLOC: begin
          if (alloc_ok) in_use_r <= in_use_r + USE_W'(1);
        end
        REQ_CONFIG: begin
          if (ch_ok) begin
            rep_r[ch_idx] <= rep_req_r;
            per_r[ch_idx] <= reload_r;
            cnt_r[ch_idx] <= '0;
            en_r[ch_idx]  <= 1'b0;
          end
        end
        REQ_START: begin
          if (ch_ok) begin
            cnt_r[ch_idx] <= '0;
            en_r[ch_idx]  <= 1'b1;
          end
        end
        REQ_STOP: begin
          if (ch_ok) en_r[ch_idx] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_ok_r    <= ok_nxt;
      out_grant_r <= grant_nxt;
      out_mask_r  <= (req_r == REQ_TICK) ? MASK_W'(mask_r) : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_ok              = out_ok_r;
  assign out_granted_channel = out_grant_r;
  assign out_expired_mask    = out_mask_r;

  `MCSTB_ASSERT_SAME(a_in_use_bound, 1'b1, in_use_r <= USE_W'(NUM_CHANNELS),
                     "channels in use beyond bank size")
  `MCSTB_ASSERT_NEXT(a_mask_cleared, cmd.capture, mask_r == '0,
                     "expired mask not cleared on capture")
  `MCSTB_ASSERT_NEXT(a_finish_loads, cmd.finish, out_valid_r,
                     "finish did not load the output register")
  `MCSTB_ASSERT_SAME(a_mask_implies_ok, out_valid_r && (out_mask_r != '0), out_ok_r,
                     "expired mask on a rejected request")

endmodule

[rtl/multi_channel_soft_timer_bank_core.sv]
// Channel   Dir  Handshake     Payload
// in_req    in   valid/ready   req_type[3], channel[4], periodic[1], reload_value[32]
// out_rsp   out  valid/ready   ok[1], granted_channel[3], expired_mask[8]
//
// A tick is captured, then sweeps every channel (the sweep visits one channel per
// cycle), then writes its result to the output register in the finish step. Any other
// request skips the sweep; a new beat is taken only back in idle, after the finish step.
// rst_n is synchronous; it clears all channel state at once, with no clearing pass.
// The result waits in an output register; the next beat is accepted while it waits, and
// that request holds in its finish step until the register frees up.
module multi_channel_soft_timer_bank_core #(
  parameter int NUM_CHANNELS = mcstb_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_BITS   = mcstb_pkg::COUNT_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  mcstb_req_if.sink   in_req,
  mcstb_rsp_if.source out_rsp
);
  import mcstb_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  logic       in_ready;

  // Controller: sequence capture, channel sweep and result write-back.
  mcstb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_req.ready = in_ready;

  // Datapath: channel registers, sweep unit and output register.
  mcstb_dp #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_req_type         (in_req.req_type),
    .in_channel          (in_req.channel),
    .in_periodic         (in_req.periodic),
    .in_reload_value     (in_req.reload_value),
    .out_valid           (out_rsp.valid),
    .out_ready           (out_rsp.ready),
    .out_ok              (out_rsp.ok),
    .out_granted_channel (out_rsp.granted_channel),
    .out_expired_mask    (out_rsp.expired_mask)
  );

endmodule

[tb/timer_bank_checker.sv]
`timescale 1ns / 100ps

module timer_bank_checker
  import mcstb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  mcstb_req_if        req,
  mcstb_rsp_if        rsp,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct packed {
    logic               ok;
    logic [GRANT_W-1:0] granted_channel;
    logic [MASK_W-1:0]  expired_mask;
  } timer_rsp_t;

  // Shadow copy of the timer bank.
  logic [NUM_CHANNELS_DEF-1:0] chan_running;
  logic [NUM_CHANNELS_DEF-1:0] chan_periodic;
  logic [COUNT_BITS_DEF-1:0]   chan_elapsed [NUM_CHANNELS_DEF];
  logic [COUNT_BITS_DEF-1:0]   chan_reload  [NUM_CHANNELS_DEF];
  int unsigned                 alloc_count;

  timer_rsp_t  rsp_expected_q [$];
  int unsigned mismatches;

  // Apply one request to the shadow bank and return the response it earns.
  function automatic timer_rsp_t timer_bank_apply(input logic [REQ_W-1:0]    kind,
                                                  input logic [CH_W-1:0]     ch,
                                                  input logic                periodic,
                                                  input logic [RELOAD_W-1:0] reload);
    timer_rsp_t r;
    logic       ch_ok;
    r     = '0;
    ch_ok = (ch < NUM_CHANNELS_DEF);
    case (kind)
      REQ_TICK: begin
        r.ok = 1'b1;
        for (int i = 0; i < NUM_CHANNELS_DEF; i++) begin
          if (i < alloc_count && chan_running[i]) begin
            chan_elapsed[i] = chan_elapsed[i] + 1'b1;
            if (chan_elapsed[i] >= chan_reload[i]) begin
              r.expired_mask[i] = 1'b1;
              chan_elapsed[i]   = '0;
              if (!chan_periodic[i]) chan_running[i] = 1'b0;
            end
          end
        end
      end
      REQ_ALLOC: begin
        if (alloc_count < NUM_CHANNELS_DEF) begin
          r.ok              = 1'b1;
          r.granted_channel = alloc_count[GRANT_W-1:0];
          alloc_count++;
        end
      end
      REQ_CONFIG: begin
        if (ch_ok) begin
          r.ok              = 1'b1;
          chan_periodic[ch] = periodic;
          chan_reload[ch]   = reload[COUNT_BITS_DEF-1:0];
          chan_elapsed[ch]  = '0;
          chan_running[ch]  = 1'b0;
        end
      end
      REQ_START: begin
        if (ch_ok) begin
          r.ok             = 1'b1;
          chan_elapsed[ch] = '0;
          chan_running[ch] = 1'b1;
        end
      end
      REQ_STOP: begin
        if (ch_ok) begin
          r.ok             = 1'b1;
          chan_running[ch] = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    timer_rsp_t want;
    if (!rst_n) begin
      chan_running  = '0;
      chan_periodic = '0;
      for (int i = 0; i < NUM_CHANNELS_DEF; i++) begin
        chan_elapsed[i] = '0;
        chan_reload[i]  = '0;
      end
      alloc_count = 0;
      mismatches  = 0;
      rsp_expected_q.delete();
    end else begin
      // Retire the response beat first: it always belongs to an older request.
      if (rsp.valid && rsp.ready) begin
        if (rsp_expected_q.size() == 0) begin
          $error("response beat with no request outstanding");
          mismatches++;
        end else begin
          want = rsp_expected_q.pop_front();
          if (rsp.ok !== want.ok) begin
            $error("ok: expected %0d, actual %0d", want.ok, rsp.ok);
            mismatches++;
          end
          if (rsp.granted_channel !== want.granted_channel) begin
            $error("granted_channel: expected %0d, actual %0d",
                   want.granted_channel, rsp.granted_channel);
            mismatches++;
          end
          if (rsp.expired_mask !== want.expired_mask) begin
            $error("expired_mask: expected 0x%02h, actual 0x%02h",
                   want.expired_mask, rsp.expired_mask);
            mismatches++;
          end
        end
      end
      if (req.valid && req.ready)
        rsp_expected_q.push_back(timer_bank_apply(req.req_type, req.channel,
                                                  req.periodic, req.reload_value));
    end
    fail_count <= mismatches;
    pending    <= rsp_expected_q.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import mcstb_pkg::*;

  // Request codes the block does not define; they must be refused.
  localparam logic [REQ_W-1:0] REQ_RSVD5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

  // Channel indexes just past the bank and at the top of the field.
  localparam logic [CH_W-1:0] CH_FIRST_BAD = CH_W'(NUM_CHANNELS_DEF);
  localparam logic [CH_W-1:0] CH_TOP       = 4'hF;

  localparam logic [RELOAD_W-1:0] RELOAD_MAX = '1;

  localparam int RANDOM_ITEMS = 1520;
  localparam int PHASE_ITEMS  = RANDOM_ITEMS / 4;
  localparam int HOLD_CYCLES  = 300;

  logic clk = 1'b0;
  logic rst_n;

  mcstb_req_if req_ch ();
  mcstb_rsp_if rsp_ch ();

  int unsigned fail_count;
  int unsigned pending;

  // Percent chance that the sender idles / the receiver stalls in a cycle.
  int send_idle = 0;
  int rsp_stall = 0;

  logic hold_active = 1'b0;
  event hold_ev;

  int items_sent;

  multi_channel_soft_timer_bank_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  timer_bank_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  // Backstop: report an error and stop if the run hangs.
  initial begin
    #4_000_000;
    $display("[multi_channel_soft_timer_bank_core] ERROR");
    $finish;
  end

  // Receiver: stall at random, or hold off completely while a long hold runs.
  always @(posedge clk) begin
    if (!rst_n)
      rsp_ch.ready <= 1'b0;
    else if (hold_active)
      rsp_ch.ready <= 1'b0;
    else
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall);
  end

  // Long hold: keep the receiver off so the output register fills and
  // the block backs up onto the request channel.
  initial begin
    forever begin
      @(hold_ev);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  // Offer one request beat and return at the edge that accepts it. Valid
  // stays high on return, so back-to-back beats never touch valid twice in
  // one step; only an idle gap lowers it.
  task automatic send_req(input logic [REQ_W-1:0]    kind,
                          input logic [CH_W-1:0]     ch,
                          input logic                periodic,
                          input logic [RELOAD_W-1:0] reload);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.channel      <= ch;
    req_ch.periodic     <= periodic;
    req_ch.reload_value <= reload;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  // Mostly in-bank channels, now and then one past the end of the bank, up to the top of the field.
  function automatic logic [CH_W-1:0] pick_channel();
    if ($urandom_range(99) < 85)
      return CH_W'($urandom_range(NUM_CHANNELS_DEF - 1));
    return CH_W'($urandom_range(15, NUM_CHANNELS_DEF));
  endfunction

  // Short reloads so channels expire often; wide values and corners now and then.
  function automatic logic [RELOAD_W-1:0] pick_reload();
    int r;
    r = $urandom_range(99);
    if (r < 50) return RELOAD_W'($urandom_range(5));
    if (r < 75) return RELOAD_W'($urandom_range(40));
    if (r < 90) return RELOAD_W'($urandom);
    if (r < 95) return RELOAD_MAX;
    return '0;
  endfunction

  task automatic send_random_item();
    int                  r;
    logic [REQ_W-1:0]    kind;
    r = $urandom_range(99);
    if (r < 35)      kind = REQ_TICK;
    else if (r < 50) kind = REQ_CONFIG;
    else if (r < 65) kind = REQ_START;
    else if (r < 78) kind = REQ_STOP;
    else if (r < 84) kind = REQ_ALLOC;
    else if (r < 92) kind = REQ_W'($urandom_range(7, 5));
    else             kind = REQ_W'($urandom_range(7));
    send_req(kind, pick_channel(), 1'($urandom_range(1)), pick_reload());
  endtask

  // A well-formed timer run: configure, start, then a burst of ticks.
  task automatic send_timer_run();
    logic [CH_W-1:0] ch;
    int              n_ticks;
    ch      = CH_W'($urandom_range(NUM_CHANNELS_DEF - 1));
    n_ticks = $urandom_range(6, 1);
    send_req(REQ_CONFIG, ch, 1'($urandom_range(1)), pick_reload());
    send_req(REQ_START, ch, 1'($urandom_range(1)), RELOAD_W'($urandom));
    repeat (n_ticks)
      send_req(REQ_TICK, pick_channel(), 1'($urandom_range(1)), RELOAD_W'($urandom));
  endtask

  initial begin
    int phase;
    // Drive every block input to a known value before the first edge.
    rst_n               = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_TICK;
    req_ch.channel      = '0;
    req_ch.periodic     = 1'b0;
    req_ch.reload_value = '0;
    rsp_ch.ready        = 1'b0;
    items_sent          = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    // Tick on an empty bank.
    send_req(REQ_TICK, '0, 1'b0, '0);
    // Configure and start a channel before it is allocated: accepted, but
    // ticks must leave it alone.
    send_req(REQ_CONFIG, 4'd0, 1'b0, '0);
    send_req(REQ_START, 4'd0, 1'b0, '0);
    send_req(REQ_TICK, '0, 1'b0, '0);
    // Allocate the whole bank, then once more to hit the no-free-channel case.
    repeat (NUM_CHANNELS_DEF + 1) send_req(REQ_ALLOC, '0, 1'b0, '0);
    // Zero reload on a one-shot: expires on the first tick and drops out.
    send_req(REQ_TICK, '0, 1'b0, '0);
    // Widest reload on a repeating channel: never expires here.
    send_req(REQ_CONFIG, 4'd7, 1'b1, RELOAD_MAX);
    send_req(REQ_START, 4'd7, 1'b1, RELOAD_MAX);
    send_req(REQ_TICK, CH_TOP, 1'b1, RELOAD_MAX);
    send_req(REQ_STOP, 4'd7, 1'b0, '0);
    // Out-of-range channels.
    send_req(REQ_CONFIG, CH_FIRST_BAD, 1'b1, 32'd1);
    send_req(REQ_STOP, CH_TOP, 1'b0, '0);
    // Undefined request codes, two of them with every payload bit set.
    send_req(REQ_RSVD5, CH_TOP, 1'b1, RELOAD_MAX);
    send_req(REQ_RSVD6, CH_TOP, 1'b1, RELOAD_MAX);
    send_req(REQ_RSVD7, '0, 1'b0, '0);
    // Repeating channel with reload 2: expires on the second tick, then rearms.
    send_req(REQ_CONFIG, 4'd1, 1'b1, 32'd2);
    send_req(REQ_START, 4'd1, 1'b0, '0);
    repeat (3) send_req(REQ_TICK, '0, 1'b0, '0);

    // Random part, one idling profile per phase.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  rsp_stall <= 0;  end
        1: begin send_idle = 45; rsp_stall <= 0;  end
        2: begin send_idle = 0;  rsp_stall <= 45; end
        default: begin send_idle = 33; rsp_stall <= 33; end
      endcase
      while (items_sent < 30 + (phase + 1) * PHASE_ITEMS) begin
        // Kick off the long hold partway into the no-idle phase and keep
        // offering beats through it.
        if (phase == 0 && items_sent >= 130 && items_sent < 140 && !hold_active)
          -> hold_ev;
        if ($urandom_range(99) < 60)
          send_timer_run();
        else
          send_random_item();
      end
    end

    // Drop valid after the last beat and drain. Wait for a clock edge first so the
    // outstanding count already includes the last beat.
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2 * NUM_CHANNELS_DEF + 8) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("[multi_channel_soft_timer_bank_core] OK");
    else
      $display("[multi_channel_soft_timer_bank_core] ERROR");
    $finish;
  end

endmodule
